/* hdl/bole_pkg.sv */
// Package: shared types, constants and opcodes for the ordered list engine.
package bole_pkg;

  localparam int unsigned Capacity = 128;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = $clog2(Capacity + 1);

  localparam logic [2:0] OpAppend  = 3'd0;
  localparam logic [2:0] OpInsert  = 3'd1;
  localparam logic [2:0] OpDelKey  = 3'd2;
  localparam logic [2:0] OpDelPos  = 3'd3;
  localparam logic [2:0] OpSearch  = 3'd4;
  localparam logic [2:0] OpGet     = 3'd5;
  localparam logic [2:0] OpLength  = 3'd6;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StFull     = 2'd1;
  localparam logic [1:0] StNotFound = 2'd2;
  localparam logic [1:0] StAppended = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] key;
    logic [31:0]        payload;
    logic [7:0]         position;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_key;
    logic [31:0]        found_payload;
    logic [7:0]         length;
  } rsp_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
  } entry_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic        ins;       // open a slot at ins_idx, shift later entries up
    logic [IdxW-1:0] ins_idx;
    entry_t      ins_ent;
    logic        compact;   // drop the cell at idx, shifting later entries down
    logic        mark;      // mark cells whose key matches / whose index matches
    logic        by_key;
    logic [31:0] key;
    logic [IdxW-1:0] idx;
  } cell_cmd_t;

endpackage

/* hdl/bole_cell.sv */
// One list cell: holds an entry and a drop mark, shifts with its neighbors.
module bole_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [bole_pkg::IdxW-1:0]   my_idx_i,
  input  logic                        in_use_i,
  input  bole_pkg::cell_cmd_t         cmd_i,
  input  bole_pkg::entry_t            lo_ent_i,
  input  bole_pkg::entry_t            hi_ent_i,
  input  logic                        hi_mark_i,
  output bole_pkg::entry_t            ent_o,
  output logic                        mark_o,
  output logic                        hit_o
);
  bole_pkg::entry_t ent_q, ent_d;
  logic             mark_q, mark_d;

  assign hit_o = in_use_i && (ent_q.key == cmd_i.key);

  always_comb begin
    ent_d  = ent_q;
    mark_d = mark_q;
    if (cmd_i.ins) begin
      if (my_idx_i == cmd_i.ins_idx) begin
        ent_d = cmd_i.ins_ent;
      end else if (my_idx_i > cmd_i.ins_idx) begin
        ent_d = lo_ent_i;
      end
    end else if (cmd_i.mark) begin
      mark_d = in_use_i && (cmd_i.by_key ? hit_o : (my_idx_i == cmd_i.idx));
    end else if (cmd_i.compact) begin
      // drop the cell at idx: it and every cell above take the upper neighbor
      if (my_idx_i >= cmd_i.idx) begin
        ent_d  = hi_ent_i;
        mark_d = hi_mark_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mark_q <= 1'b0;
    end else begin
      mark_q <= mark_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign ent_o  = ent_q;
  assign mark_o = mark_q;
endmodule

/* hdl/bounded_ordered_list_engine.sv */
// Top level: ordered list of key/payload entries held in a chain of cells.
//
// The list lives in a row of Capacity cells, entry N in cell N-1. Append and
// insert shift the cells above the insert point up by one. Search and
// retrieve compare or select across all cells in parallel. Delete first marks
// the cells to drop (every key match, or the one position), then drops the
// lowest marked cell per cycle by shifting the cells above it down one, then
// writes the result in S_COMP. A delete with nothing to drop writes its
// result from S_EXEC, as every other request does. A request is taken only
// while no other is in work, so no new request is taken until the result of
// the last is loaded. While an earlier result waits unread, the next request
// may be taken but holds before its result-writing cycle. Exactly one result
// per request. Storage has no reset; only cells below the count are ever
// read.
module bounded_ordered_list_engine (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  bole_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output bole_pkg::rsp_t  out_data_o
);
  localparam int unsigned N = bole_pkg::Capacity;
  localparam int unsigned IW = bole_pkg::IdxW;
  localparam int unsigned CW = bole_pkg::CntW;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_COMP = 3'b100
  } state_e;

  state_e              state_q, state_d;
  bole_pkg::req_t      req_q;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic                ov_q;
  bole_pkg::rsp_t      rsp_q, rsp_d;
  logic                ov_set;
  logic                slot_free;
  bole_pkg::cell_cmd_t cmd;

  bole_pkg::entry_t ent   [N];
  logic [N-1:0]     marks;
  logic [N-1:0]     marks_up;
  logic [N-1:0]     hits;
  logic [N-1:0]     in_use;

  // accept only when no request is in work
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;
  assign out_data_o  = rsp_q;

  // the result register can take a new result when empty or draining now
  assign slot_free = !ov_q || out_ready_i;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      in_use[i] = (CW'(i) < cnt_q);
    end
  end

  // mark seen by each cell from its upper neighbor; nothing above the top cell
  assign marks_up = {1'b0, marks[N-1:1]};

  // first hit search: lowest matching cell
  logic [IW-1:0] hit_idx;
  logic          hit_any;
  always_comb begin
    hit_idx = '0;
    hit_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_idx = IW'(i);
        hit_any = 1'b1;
      end
    end
  end

  // lowest marked cell, dropped next during compaction
  logic [IW-1:0] mark_idx;
  logic          mark_any;
  always_comb begin
    mark_idx = '0;
    mark_any = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (marks[i]) begin
        mark_idx = IW'(i);
        mark_any = 1'b1;
      end
    end
  end

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      bole_cell u_cell (
        .clk_i        (clk_i),
        .rst_ni       (rst_ni),
        .my_idx_i     (IW'(g)),
        .in_use_i     (in_use[g]),
        .cmd_i        (cmd),
        .lo_ent_i     (ent[(g == 0) ? 0 : g - 1]),
        .hi_ent_i     (ent[(g == N - 1) ? g : g + 1]),
        .hi_mark_i    (marks_up[g]),
        .ent_o        (ent[g]),
        .mark_o       (marks[g]),
        .hit_o        (hits[g])
      );
    end
  endgenerate

  logic [8:0] pos_eff;
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rsp_d   = rsp_q;
    ov_set  = 1'b0;
    cmd     = '0;
    cmd.key = req_q.key;
    cmd.by_key = (req_q.opcode == bole_pkg::OpDelKey);
    cmd.ins_ent.key = req_q.key;
    cmd.ins_ent.payload = req_q.payload;
    pos_eff = (req_q.position == 8'd0) ? 9'd1 : {1'b0, req_q.position};
    cmd.idx = IW'(pos_eff - 9'd1);
    cmd.ins_idx = IW'(cnt_q);
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) state_d = S_EXEC;
      end
      S_EXEC: begin
        // hold the request until the result register is free
        if (slot_free) begin
          rsp_d.status        = bole_pkg::StNotFound;
          rsp_d.found_key     = '0;
          rsp_d.found_payload = '0;
          state_d = S_IDLE;
          ov_set  = 1'b1;
          case (req_q.opcode)
            bole_pkg::OpAppend, bole_pkg::OpInsert: begin
              if (cnt_q >= CW'(N)) begin
                rsp_d.status = bole_pkg::StFull;
              end else begin
                cmd.ins = 1'b1;
                cnt_d   = cnt_q + CW'(1);
                if (req_q.opcode == bole_pkg::OpAppend) begin
                  rsp_d.status = bole_pkg::StOk;
                end else if (pos_eff > 9'(cnt_q)) begin
                  rsp_d.status = bole_pkg::StAppended;
                end else begin
                  cmd.ins_idx  = IW'(pos_eff - 9'd1);
                  rsp_d.status = bole_pkg::StOk;
                end
              end
            end
            bole_pkg::OpDelKey: begin
              cmd.mark = 1'b1;
              if (hit_any) begin
                state_d = S_COMP;
                ov_set  = 1'b0;
              end
            end
            bole_pkg::OpDelPos: begin
              if (req_q.position != 8'd0 && 9'(req_q.position) <= 9'(cnt_q)) begin
                cmd.mark = 1'b1;
                state_d  = S_COMP;
                ov_set   = 1'b0;
              end
            end
            bole_pkg::OpSearch: begin
              if (hit_any) begin
                rsp_d.status        = bole_pkg::StOk;
                rsp_d.found_key     = ent[hit_idx].key;
                rsp_d.found_payload = ent[hit_idx].payload;
              end
            end
            bole_pkg::OpGet: begin
              if (req_q.position != 8'd0 && 9'(req_q.position) <= 9'(cnt_q)) begin
                rsp_d.status        = bole_pkg::StOk;
                rsp_d.found_key     = ent[cmd.idx].key;
                rsp_d.found_payload = ent[cmd.idx].payload;
              end
            end
            bole_pkg::OpLength: rsp_d.status = bole_pkg::StOk;
            default: rsp_d.status = bole_pkg::StNotFound;
          endcase
          rsp_d.length = 8'(cnt_d);
        end
      end
      S_COMP: begin
        if (mark_any) begin
          // drop the lowest marked cell and shift the cells above it down
          cmd.compact = 1'b1;
          cmd.idx     = mark_idx;
          cnt_d       = cnt_q - CW'(1);
        end else if (slot_free) begin
          rsp_d.status        = bole_pkg::StOk;
          rsp_d.found_key     = '0;
          rsp_d.found_payload = '0;
          rsp_d.length        = 8'(cnt_q);
          ov_set  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (ov_set) ov_q <= 1'b1;
      else if (out_ready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
  end

  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(N)) else $error("count over capacity");
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_comp_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMP) |=> (state_q == S_COMP) || ((state_q == S_IDLE) && ov_q))
    else $error("compact step lost");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while waiting");
endmodule

/* test/tb_bounded_ordered_list_engine.sv */
// Testbench for the ordered list engine: random and directed requests, scoreboard check.
`timescale 1ns / 100ps

// Scoreboard: mirrors the list and queues one expected response per request.
class list_scoreboard;
  bit [31:0] keys[$];
  bit [31:0] pays[$];
  bole_pkg::rsp_t pending_rsp[$];
  int errors;
  int checked;

  // Apply one accepted request to the mirror and queue its response.
  function void note_request(bole_pkg::req_t rq);
    bole_pkg::rsp_t r;
    int pos;
    bit hit;
    r = '0;
    r.status = bole_pkg::StNotFound;
    pos = rq.position;
    case (rq.opcode)
      bole_pkg::OpAppend: begin
        if (keys.size() >= bole_pkg::Capacity) r.status = bole_pkg::StFull;
        else begin
          keys.push_back(rq.key);
          pays.push_back(rq.payload);
          r.status = bole_pkg::StOk;
        end
      end
      bole_pkg::OpInsert: begin
        if (pos == 0) pos = 1;
        if (keys.size() >= bole_pkg::Capacity) r.status = bole_pkg::StFull;
        else if (pos > keys.size()) begin
          keys.push_back(rq.key);
          pays.push_back(rq.payload);
          r.status = bole_pkg::StAppended;
        end else begin
          keys.insert(pos - 1, rq.key);
          pays.insert(pos - 1, rq.payload);
          r.status = bole_pkg::StOk;
        end
      end
      bole_pkg::OpDelKey: begin
        for (int i = keys.size() - 1; i >= 0; i--) begin
          if (keys[i] == rq.key) begin
            keys.delete(i);
            pays.delete(i);
            r.status = bole_pkg::StOk;
          end
        end
      end
      bole_pkg::OpDelPos: begin
        if (pos >= 1 && pos <= keys.size()) begin
          keys.delete(pos - 1);
          pays.delete(pos - 1);
          r.status = bole_pkg::StOk;
        end
      end
      bole_pkg::OpSearch: begin
        hit = 0;
        foreach (keys[i]) begin
          if (!hit && keys[i] == rq.key) begin
            hit = 1;
            r.found_key = keys[i];
            r.found_payload = pays[i];
            r.status = bole_pkg::StOk;
          end
        end
      end
      bole_pkg::OpGet: begin
        if (pos >= 1 && pos <= keys.size()) begin
          r.found_key = keys[pos - 1];
          r.found_payload = pays[pos - 1];
          r.status = bole_pkg::StOk;
        end
      end
      bole_pkg::OpLength: r.status = bole_pkg::StOk;
      default: r.status = bole_pkg::StNotFound;
    endcase
    r.length = 8'(keys.size());
    pending_rsp.push_back(r);
  endfunction

  // Compare one accepted response with the oldest expectation.
  function void check_response(bole_pkg::rsp_t act);
    bole_pkg::rsp_t exp_r;
    checked++;
    if (pending_rsp.size() == 0) begin
      $display("%0t: unexpected response %h", $time, act);
      errors++;
      return;
    end
    exp_r = pending_rsp.pop_front();
    if (exp_r.status !== act.status) begin
      $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
      errors++;
    end
    if (exp_r.found_key !== act.found_key) begin
      $display("%0t: found_key exp %0d got %0d", $time, exp_r.found_key, act.found_key);
      errors++;
    end
    if (exp_r.found_payload !== act.found_payload) begin
      $display("%0t: found_payload exp %h got %h", $time, exp_r.found_payload,
               act.found_payload);
      errors++;
    end
    if (exp_r.length !== act.length) begin
      $display("%0t: length exp %0d got %0d", $time, exp_r.length, act.length);
      errors++;
    end
  endfunction
endclass

module tb_bounded_ordered_list_engine;

  localparam int RandomItems = 890;
  localparam int StallLimit  = 20000;
  localparam int HoldCycles  = 300;
  localparam logic [2:0] OpIllegal = 3'd7;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  bole_pkg::req_t in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  bole_pkg::rsp_t out_data_o;

  list_scoreboard board;
  bit   hold_off;      // long receiver stall requested by the stimulus
  int   idle_cycles;
  int   sent;

  bounded_ordered_list_engine u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one request; hold valid and payload until the transfer happens.
  task automatic send_request(input bole_pkg::req_t rq);
    in_valid_i <= 1'b1;
    in_data_i  <= rq;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(rq);
    sent++;
  endtask

  // Drop valid for a random gap, or keep it up for back-to-back transfers.
  task automatic sender_gap(input int max_gap);
    int n;
    n = $urandom_range(0, max_gap);
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  function automatic bole_pkg::req_t make_req(logic [2:0] op, logic [31:0] k,
                                              logic [31:0] p, logic [7:0] pos);
    bole_pkg::req_t rq;
    rq.opcode = op;
    rq.key = k;
    rq.payload = p;
    rq.position = pos;
    return rq;
  endfunction

  // Keys come mostly from a small pool so that searches and deletes hit.
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'h8000_0000 + $urandom_range(0, 3);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [7:0] pick_pos(int len);
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'($urandom());
      2: return 8'(len + 1);
      default: return 8'($urandom_range(1, len > 0 ? len : 1));
    endcase
  endfunction

  // Weight the opcode mix by the grow flag so the count roams empty to full.
  function automatic bole_pkg::req_t random_req(bit grow);
    int len;
    logic [2:0] op;
    int r;
    len = board.keys.size();
    r = $urandom_range(0, 99);
    if (r < (grow ? 45 : 15)) op = bole_pkg::OpAppend;
    else if (r < (grow ? 65 : 30)) op = bole_pkg::OpInsert;
    else if (r < 45) op = bole_pkg::OpDelKey;
    else if (r < 62) op = bole_pkg::OpDelPos;
    else if (r < 76) op = bole_pkg::OpSearch;
    else if (r < 90) op = bole_pkg::OpGet;
    else if (r < 97) op = bole_pkg::OpLength;
    else op = OpIllegal;
    return make_req(op, pick_key(), $urandom(), pick_pos(len));
  endfunction

  // Receiver: random stall pattern, bursts of full readiness, and long hold-offs.
  initial begin
    int mode;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(5, 40)) begin
        @(posedge clk_i);
        if (hold_off) begin
          // hold off for a long stretch, counted here
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          hold_off = 1'b0;
        end
        else if (mode < 3) out_ready_i <= 1'b1;
        else out_ready_i <= ($urandom_range(0, 9) < mode);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_response(out_data_o);
  end

  // Watchdog: cycles with no transfer on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", StallLimit);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    board = new();
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    hold_off = 1'b0;
    idle_cycles = 0;
    sent = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty-list corners, field extremes, every opcode.
    send_request(make_req(bole_pkg::OpDelKey, 32'd5, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpDelPos, 32'd0, 32'd0, 8'd1));
    send_request(make_req(bole_pkg::OpGet, 32'd0, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpSearch, 32'd0, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpInsert, 32'h7fff_ffff, 32'hffff_ffff, 8'd0));
    send_request(make_req(bole_pkg::OpInsert, 32'h8000_0000, 32'h0, 8'd200));
    send_request(make_req(bole_pkg::OpAppend, 32'hffff_ffff, 32'h1234_5678, 8'hff));
    send_request(make_req(bole_pkg::OpInsert, 32'd7, 32'h5555_aaaa, 8'd2));
    send_request(make_req(bole_pkg::OpAppend, 32'h8000_0000, 32'haaaa_5555, 8'd0));
    send_request(make_req(bole_pkg::OpSearch, 32'h8000_0000, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpSearch, 32'd99, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpGet, 32'd0, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpGet, 32'd0, 32'd0, 8'd5));
    send_request(make_req(bole_pkg::OpGet, 32'd0, 32'd0, 8'd6));
    send_request(make_req(bole_pkg::OpLength, 32'd0, 32'd0, 8'd0));
    send_request(make_req(OpIllegal, 32'd0, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpDelKey, 32'h8000_0000, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpDelPos, 32'd0, 32'd0, 8'd0));
    send_request(make_req(bole_pkg::OpDelPos, 32'd0, 32'd0, 8'd9));
    send_request(make_req(bole_pkg::OpDelPos, 32'd0, 32'd0, 8'd2));

    // Fill to capacity, then try both adds against the full list.
    while (board.keys.size() < bole_pkg::Capacity)
      send_request(make_req(bole_pkg::OpAppend, pick_key(), $urandom(), 8'd0));
    send_request(make_req(bole_pkg::OpAppend, 32'd1, 32'd1, 8'd0));
    send_request(make_req(bole_pkg::OpInsert, 32'd1, 32'd1, 8'd1));
    send_request(make_req(bole_pkg::OpGet, 32'd0, 32'd0, 8'd128));
    send_request(make_req(bole_pkg::OpDelPos, 32'd0, 32'd0, 8'd128));
    in_valid_i <= 1'b0;

    // Pause the sender until the block has drained every response.
    while (board.pending_rsp.size() != 0) @(posedge clk_i);

    // Long receiver hold-off while requests keep coming, to back up the input.
    hold_off = 1'b1;
    repeat (8) send_request(random_req(1'b0));
    in_valid_i <= 1'b0;

    // Random phase: alternate growing and shrinking epochs.
    for (int i = 0; i < RandomItems; i++) begin
      send_request(random_req(((i / 150) % 2) == 0));
      if ($urandom_range(0, 3) == 0) sender_gap($urandom_range(0, 1) ? 2 : 12);
    end
    in_valid_i <= 1'b0;

    while (board.pending_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d requests over all opcodes, empty through full list;", sent);
    $display("checked %0d responses with random stalls on both sides.", board.checked);
    if (board.errors == 0 && board.pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
